FILE: design/sof_deframer_pkg.sv
// Package for the start-of-frame / length / checksum deframer.
// Holds field widths, byte codes, role and status codes and the phase type.
// No dependencies.
`timescale 1ns / 1ps

package sof_deframer_pkg;

  // Field widths
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned LEN_W    = 16;
  localparam int unsigned ROLE_W   = 3;
  localparam int unsigned ID_W     = 4;
  localparam int unsigned STATUS_W = 2;

  // Packed stream widths
  localparam int unsigned IN_TDATA_W  = 8;
  localparam int unsigned OUT_TDATA_W = 16;
  localparam int unsigned OUT_TUSER_W = ROLE_W;

  // Configuration port
  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned CFG_DATA_W = 32;
  localparam logic [CFG_ADDR_W-1:0] ADDR_LEN_LIMIT = 3'd0;
  localparam logic [LEN_W-1:0]      MAX_LEN_RESET  = 16'd256;

  // Frame byte codes
  localparam logic [BYTE_W-1:0] START_BYTE  = 8'h5A;
  localparam logic [BYTE_W-1:0] SUM_OK      = 8'hFF;
  localparam logic [LEN_W-1:0]  LEN_HI_MASK = 16'hFF00;

  // Byte roles
  typedef enum logic [ROLE_W-1:0] {
    ROLE_OUTSIDE = 3'd0,
    ROLE_START   = 3'd1,
    ROLE_ID      = 3'd2,
    ROLE_LEN_HI  = 3'd3,
    ROLE_LEN_LO  = 3'd4,
    ROLE_BODY    = 3'd5
  } role_t;

  // Frame status, meaningful on the closing word only
  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 2'd0,
    ST_BAD_SUM = 2'd1,
    ST_BAD_LEN = 2'd2,
    ST_TRUNC   = 2'd3
  } status_t;

  // Parser phase, one-hot
  typedef enum logic [4:0] {
    PH_HUNT   = 5'b00001,
    PH_ID     = 5'b00010,
    PH_LEN_HI = 5'b00100,
    PH_LEN_LO = 5'b01000,
    PH_BODY   = 5'b10000
  } phase_t;

endpackage

FILE: design/sof_length_checksum_deframer_core.sv
// An accepted input word passes the input register and then the output register on its way to out_*.
// One word per cycle while the output is not stalled; the only loop is the phase/sum update.
// A result held on a stalled output does not block an empty input register, which
// still takes one word and then holds it until the output moves.
// Reset (rst_n, synchronous, active low): hunt for start byte, sums and counts
// cleared, length limit = 256, both pipeline registers empty.
// Depends on sof_deframer_pkg.
`timescale 1ns / 1ps

module sof_length_checksum_deframer_core (
  input  logic        clk,
  input  logic        rst_n,
  // Input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [sof_deframer_pkg::IN_TDATA_W-1:0]  in_tdata,  // [7:0] rx_byte
  input  logic        in_tlast,                               // end_of_burst
  // Result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  // [7:0] data_byte, [11:8] frame_id, [13:12] frame_status, [15:14] zero
  output logic [sof_deframer_pkg::OUT_TDATA_W-1:0] out_tdata,
  output logic [sof_deframer_pkg::OUT_TUSER_W-1:0] out_tuser, // [2:0] byte_role
  output logic        out_tlast,                              // frame_end
  // Configuration port
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [sof_deframer_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [sof_deframer_pkg::CFG_DATA_W-1:0] cfg_pwdata,
  output logic [sof_deframer_pkg::CFG_DATA_W-1:0] cfg_prdata,
  output logic        cfg_pready
);

  // Configuration register
  logic [sof_deframer_pkg::LEN_W-1:0] max_len_r;
  logic cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready
                  && (cfg_paddr == sof_deframer_pkg::ADDR_LEN_LIMIT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_len_r <= sof_deframer_pkg::MAX_LEN_RESET;
    end else if (cfg_wr) begin
      max_len_r <= cfg_pwdata[sof_deframer_pkg::LEN_W-1:0];
    end
  end

  always_comb begin
    cfg_prdata = '0;
    if (cfg_paddr == sof_deframer_pkg::ADDR_LEN_LIMIT) begin
      cfg_prdata = {{(sof_deframer_pkg::CFG_DATA_W-sof_deframer_pkg::LEN_W){1'b0}},
                    max_len_r};
    end
  end

  // Input register stage
  logic                                in_valid_r;
  logic [sof_deframer_pkg::BYTE_W-1:0] in_byte_r;
  logic                                in_eob_r;
  logic                                advance;

  assign advance   = in_valid_r && (!out_tvalid || out_tready);
  assign in_tready = !in_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_byte_r <= in_tdata[sof_deframer_pkg::BYTE_W-1:0];
      in_eob_r  <= in_tlast;
    end
  end

  // Frame state
  sof_deframer_pkg::phase_t            phase_r, phase_nxt;
  logic [sof_deframer_pkg::LEN_W-1:0]  remain_r, remain_nxt;
  logic [sof_deframer_pkg::BYTE_W-1:0] len_hi_r, len_hi_nxt;
  logic [sof_deframer_pkg::BYTE_W-1:0] sum_r, sum_nxt;
  logic [sof_deframer_pkg::ID_W-1:0]   id_r, id_nxt;

  // Per-word results
  sof_deframer_pkg::role_t             role;
  sof_deframer_pkg::status_t           status;
  logic                                fend;
  logic [sof_deframer_pkg::ID_W-1:0]   fid;
  logic [sof_deframer_pkg::LEN_W-1:0]  len;
  logic [sof_deframer_pkg::BYTE_W-1:0] sum_add;
  logic [sof_deframer_pkg::LEN_W-1:0]  remain_dec;

  assign sum_add    = sum_r + in_byte_r;
  assign remain_dec = remain_r - 16'd1;
  assign len = (({len_hi_r, 8'h00}) & sof_deframer_pkg::LEN_HI_MASK)
               | {8'h00, in_byte_r};

  // Next-state and result decode for the word in the input register
  always_comb begin
    phase_nxt  = phase_r;
    remain_nxt = remain_r;
    len_hi_nxt = len_hi_r;
    sum_nxt    = sum_r;
    id_nxt     = id_r;
    role       = sof_deframer_pkg::ROLE_OUTSIDE;
    status     = sof_deframer_pkg::ST_OK;
    fend       = 1'b0;

    case (phase_r)
      sof_deframer_pkg::PH_ID: begin
        role      = sof_deframer_pkg::ROLE_ID;
        id_nxt    = in_byte_r[sof_deframer_pkg::ID_W-1:0];
        sum_nxt   = sum_add;
        phase_nxt = sof_deframer_pkg::PH_LEN_HI;
      end
      sof_deframer_pkg::PH_LEN_HI: begin
        role       = sof_deframer_pkg::ROLE_LEN_HI;
        len_hi_nxt = in_byte_r;
        sum_nxt    = sum_add;
        phase_nxt  = sof_deframer_pkg::PH_LEN_LO;
      end
      sof_deframer_pkg::PH_LEN_LO: begin
        role    = sof_deframer_pkg::ROLE_LEN_LO;
        sum_nxt = sum_add;
        if (len >= max_len_r) begin
          fend      = 1'b1;
          status    = sof_deframer_pkg::ST_BAD_LEN;
          phase_nxt = sof_deframer_pkg::PH_HUNT;
        end else if (len == '0) begin
          // empty body: the length low byte closes the frame
          fend      = 1'b1;
          status    = (sum_add == sof_deframer_pkg::SUM_OK) ?
                      sof_deframer_pkg::ST_OK : sof_deframer_pkg::ST_BAD_SUM;
          phase_nxt = sof_deframer_pkg::PH_HUNT;
        end else begin
          remain_nxt = len;
          phase_nxt  = sof_deframer_pkg::PH_BODY;
        end
      end
      sof_deframer_pkg::PH_BODY: begin
        role       = sof_deframer_pkg::ROLE_BODY;
        sum_nxt    = sum_add;
        remain_nxt = remain_dec;
        if (remain_dec == '0) begin
          fend      = 1'b1;
          status    = (sum_add == sof_deframer_pkg::SUM_OK) ?
                      sof_deframer_pkg::ST_OK : sof_deframer_pkg::ST_BAD_SUM;
          phase_nxt = sof_deframer_pkg::PH_HUNT;
        end
      end
      default: begin
        phase_nxt = sof_deframer_pkg::PH_HUNT;
        if (in_byte_r == sof_deframer_pkg::START_BYTE) begin
          role      = sof_deframer_pkg::ROLE_START;
          sum_nxt   = '0;
          phase_nxt = sof_deframer_pkg::PH_ID;
        end
      end
    endcase

    // end of burst aborts a frame that is still open
    if (in_eob_r && !fend && (phase_nxt != sof_deframer_pkg::PH_HUNT)) begin
      fend      = 1'b1;
      status    = sof_deframer_pkg::ST_TRUNC;
      phase_nxt = sof_deframer_pkg::PH_HUNT;
    end
  end

  // frame id shows on id, length and body words only
  assign fid = (role == sof_deframer_pkg::ROLE_OUTSIDE || role == sof_deframer_pkg::ROLE_START)
               ? '0 : id_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= sof_deframer_pkg::PH_HUNT;
      remain_r <= '0;
      len_hi_r <= '0;
      sum_r    <= '0;
      id_r     <= '0;
    end else if (advance) begin
      phase_r  <= phase_nxt;
      remain_r <= remain_nxt;
      len_hi_r <= len_hi_nxt;
      sum_r    <= sum_nxt;
      id_r     <= id_nxt;
    end
  end

  // Output register
  logic                                     out_valid_r;
  logic [sof_deframer_pkg::OUT_TDATA_W-1:0] out_data_r;
  logic [sof_deframer_pkg::OUT_TUSER_W-1:0] out_user_r;
  logic                                     out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data_r <= {2'b00, status, fid, in_byte_r};
      out_user_r <= role;
      out_last_r <= fend;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;
  assign out_tlast  = out_last_r;

endmodule

FILE: dv/sof_length_checksum_deframer_core_test.sv
// Self-checking bench for the start-of-frame / length / checksum deframer core.
// Clocked driver and monitor around u_top, with a local parser model for expected words.
// Depends on sof_deframer_pkg and sof_length_checksum_deframer_core.
`timescale 1ns / 1ps

module sof_length_checksum_deframer_core_test;

  localparam int unsigned CYCLE_LIMIT = 200_000;
  localparam int unsigned DRAIN_CYCLES = 6;
  // widths used in size casts
  localparam int unsigned BYTE_W = sof_deframer_pkg::BYTE_W;
  localparam int unsigned LEN_W  = sof_deframer_pkg::LEN_W;

  // One byte on the input stream
  typedef struct packed {
    logic [BYTE_W-1:0] rx;
    logic              eob;
  } rx_word_t;

  // One expected result word
  typedef struct packed {
    logic [BYTE_W-1:0]                 data;
    sof_deframer_pkg::role_t           role;
    logic [sof_deframer_pkg::ID_W-1:0] fid;
    logic                              fend;
    sof_deframer_pkg::status_t         status;
  } frame_word_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                                     in_tvalid = 1'b0;
  logic                                     in_tready;
  logic [sof_deframer_pkg::IN_TDATA_W-1:0]  in_tdata = '0;   // [7:0] rx_byte
  logic                                     in_tlast = 1'b0; // end_of_burst
  logic                                     out_tvalid;
  logic                                     out_tready = 1'b0;
  // [7:0] data, [11:8] id, [13:12] status, [15:14] 0
  logic [sof_deframer_pkg::OUT_TDATA_W-1:0] out_tdata;
  logic [sof_deframer_pkg::OUT_TUSER_W-1:0] out_tuser;       // [2:0] byte_role
  logic                                     out_tlast;       // frame_end
  logic                                     cfg_psel = 1'b0;
  logic                                     cfg_penable = 1'b0;
  logic                                     cfg_pwrite = 1'b0;
  logic [sof_deframer_pkg::CFG_ADDR_W-1:0]  cfg_paddr = '0;
  logic [sof_deframer_pkg::CFG_DATA_W-1:0]  cfg_pwdata = '0;
  logic [sof_deframer_pkg::CFG_DATA_W-1:0]  cfg_prdata;
  logic                                     cfg_pready;

  sof_length_checksum_deframer_core u_top (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .out_tlast(out_tlast),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  always #1 clk = ~clk;

  rx_word_t    byte_q[$];     // bytes waiting to be sent
  frame_word_t expected_q[$]; // predicted words waiting on the output
  rx_word_t    next_byte;

  // Parser model state
  logic [LEN_W-1:0]                  max_len   = sof_deframer_pkg::MAX_LEN_RESET;
  sof_deframer_pkg::phase_t          parse_ph  = sof_deframer_pkg::PH_HUNT;
  logic [LEN_W-1:0]                  body_left = '0;
  logic [BYTE_W-1:0]                 len_hi    = '0;
  logic [BYTE_W-1:0]                 sum_acc   = '0;
  logic [sof_deframer_pkg::ID_W-1:0] cur_id    = '0;

  int unsigned errors = 0;
  int unsigned words_checked = 0;
  int unsigned status_cnt[4] = '{0, 0, 0, 0};
  int unsigned limits_run = 1;
  int unsigned cycle_cnt = 0;
  int unsigned burst_left = 0;
  int unsigned gap_left = 0;
  int unsigned ready_mode = 0;

  // Advance the parser by one byte and return the word it should produce
  function automatic frame_word_t parse_byte(input logic [BYTE_W-1:0] b, input logic eob);
    frame_word_t r;
    logic [LEN_W-1:0] len;
    r.data   = b;
    r.role   = sof_deframer_pkg::ROLE_OUTSIDE;
    r.fid    = '0;
    r.fend   = 1'b0;
    r.status = sof_deframer_pkg::ST_OK;
    case (parse_ph)
      sof_deframer_pkg::PH_ID: begin
        r.role   = sof_deframer_pkg::ROLE_ID;
        cur_id   = b[sof_deframer_pkg::ID_W-1:0];
        sum_acc  = sum_acc + b;
        parse_ph = sof_deframer_pkg::PH_LEN_HI;
      end
      sof_deframer_pkg::PH_LEN_HI: begin
        r.role   = sof_deframer_pkg::ROLE_LEN_HI;
        len_hi   = b;
        sum_acc  = sum_acc + b;
        parse_ph = sof_deframer_pkg::PH_LEN_LO;
      end
      sof_deframer_pkg::PH_LEN_LO: begin
        r.role  = sof_deframer_pkg::ROLE_LEN_LO;
        sum_acc = sum_acc + b;
        len     = {len_hi, b};
        if (len >= max_len) begin
          r.fend   = 1'b1;
          r.status = sof_deframer_pkg::ST_BAD_LEN;
          parse_ph = sof_deframer_pkg::PH_HUNT;
        end else if (len == '0) begin
          r.fend   = 1'b1;
          r.status = (sum_acc == sof_deframer_pkg::SUM_OK) ?
                     sof_deframer_pkg::ST_OK : sof_deframer_pkg::ST_BAD_SUM;
          parse_ph = sof_deframer_pkg::PH_HUNT;
        end else begin
          body_left = len;
          parse_ph  = sof_deframer_pkg::PH_BODY;
        end
      end
      sof_deframer_pkg::PH_BODY: begin
        r.role    = sof_deframer_pkg::ROLE_BODY;
        sum_acc   = sum_acc + b;
        body_left = body_left - 1'b1;
        if (body_left == '0) begin
          r.fend   = 1'b1;
          r.status = (sum_acc == sof_deframer_pkg::SUM_OK) ?
                     sof_deframer_pkg::ST_OK : sof_deframer_pkg::ST_BAD_SUM;
          parse_ph = sof_deframer_pkg::PH_HUNT;
        end
      end
      default: begin
        parse_ph = sof_deframer_pkg::PH_HUNT;
        if (b == sof_deframer_pkg::START_BYTE) begin
          r.role   = sof_deframer_pkg::ROLE_START;
          sum_acc  = '0;
          parse_ph = sof_deframer_pkg::PH_ID;
        end
      end
    endcase
    // burst ended with a frame still open
    if (eob && !r.fend && parse_ph != sof_deframer_pkg::PH_HUNT) begin
      r.fend   = 1'b1;
      r.status = sof_deframer_pkg::ST_TRUNC;
      parse_ph = sof_deframer_pkg::PH_HUNT;
    end
    if (r.role >= sof_deframer_pkg::ROLE_ID) r.fid = cur_id;
    if (!r.fend) r.status = sof_deframer_pkg::ST_OK;
    return r;
  endfunction

  task automatic push_byte(input logic [BYTE_W-1:0] b, input logic eob);
    rx_word_t w;
    w.rx  = b;
    w.eob = eob;
    byte_q.push_back(w);
  endtask

  // Queue one frame; body only when the length will be accepted.
  // trunc_at is the frame byte index that carries end of burst, -1 for none.
  task automatic push_frame(input logic [BYTE_W-1:0] id, input logic [LEN_W-1:0] len,
                            input bit good_sum, input int trunc_at, output int unsigned sent);
    logic [BYTE_W-1:0] fb[$];
    logic [BYTE_W-1:0] s;
    fb.push_back(sof_deframer_pkg::START_BYTE);
    fb.push_back(id);
    fb.push_back(len[15:8]);
    fb.push_back(len[7:0]);
    s = id + len[15:8] + len[7:0];
    if (len != '0 && len < max_len) begin
      for (int unsigned k = 0; k + 1 < len; k++) begin
        fb.push_back(BYTE_W'($urandom()));
        s = s + fb[fb.size()-1];
      end
      fb.push_back(sof_deframer_pkg::SUM_OK - s);
      if (!good_sum) fb[fb.size()-1] = fb[fb.size()-1] + BYTE_W'($urandom_range(1, 255));
    end
    sent = 0;
    foreach (fb[i]) begin
      push_byte(fb[i], i == trunc_at);
      sent++;
      if (i == trunc_at) break;
    end
  endtask

  // Random traffic: mostly frames with random content, some line noise
  task automatic push_traffic(input int unsigned target);
    int unsigned done;
    int unsigned sent;
    int unsigned r;
    int unsigned nbytes;
    int trunc_at;
    logic [LEN_W-1:0] len;
    logic [BYTE_W-1:0] id;
    bit good;
    done = 0;
    while (done < target) begin
      if ($urandom_range(0, 99) < 20) begin
        push_byte(BYTE_W'($urandom()), $urandom_range(0, 7) == 0);
      end else begin
        r = $urandom_range(0, 99);
        if (r < 10)
          len = '0;
        else if (r < 25)
          len = (max_len == 16'hFFFF) ? 16'hFFFF : LEN_W'($urandom_range(65535, max_len));
        else if (r < 32)
          len = max_len;
        else if (r < 38 && max_len >= 1 && max_len <= 65)
          len = max_len - 1'b1;
        else if (max_len >= 2)
          len = LEN_W'($urandom_range(1, (max_len - 1 < 12) ? max_len - 1 : 12));
        else
          len = '0;
        good = $urandom_range(0, 3) != 0;
        id = BYTE_W'($urandom());
        if (len == '0 && good) id = sof_deframer_pkg::SUM_OK;
        nbytes = (len != '0 && len < max_len) ? 4 + len : 4;
        trunc_at = ($urandom_range(0, 6) == 0) ? int'($urandom_range(0, nbytes - 1)) : -1;
        push_frame(id, len, good, trunc_at, sent);
        done += sent;
      end
    end
  endtask

  // APB write of the length limit; only called with the core idle
  task automatic write_max_len(input logic [LEN_W-1:0] v);
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_pwrite  <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr   <= sof_deframer_pkg::ADDR_LEN_LIMIT;
    cfg_pwdata  <= {16'($urandom()), v};
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    max_len = v;
    // read back through the still-selected address
    @(posedge clk);
    if (cfg_prdata !== {16'h0000, v}) report_mismatch("length limit readback", v, cfg_prdata);
  endtask

  // Wait for every queued byte to go through and every word to come back
  task automatic drain();
    while (byte_q.size() != 0 || in_tvalid || expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic run_limit(input logic [LEN_W-1:0] lim, input int unsigned target);
    write_max_len(lim);
    limits_run++;
    push_traffic(target);
    drain();
  endtask

  task automatic report_mismatch(input string field, input int unsigned exp_v,
                                 input int unsigned act_v);
    errors++;
    $display("%0t mismatch on %s: expected %0h, got %0h", $realtime, field, exp_v, act_v);
  endtask

  // Sender: bursts of random length with random gaps
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_tready) begin
      if (in_tvalid) expected_q.push_back(parse_byte(in_tdata, in_tlast));
      if (gap_left != 0) begin
        gap_left--;
        in_tvalid <= 1'b0;
      end else if (byte_q.size() != 0) begin
        next_byte = byte_q.pop_front();
        in_tdata  <= next_byte.rx;
        in_tlast  <= next_byte.eob;
        in_tvalid <= 1'b1;
        if (burst_left <= 1) begin
          burst_left = ($urandom_range(0, 9) == 0) ? 200 : $urandom_range(1, 30);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end else begin
          burst_left--;
        end
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: checks each accepted word; the ready pattern follows one of four randomly chosen modes
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (expected_q.size() == 0) begin
          errors++;
          $display("%0t unexpected word: tdata=%h tuser=%h tlast=%b",
                   $realtime, out_tdata, out_tuser, out_tlast);
        end else begin
          frame_word_t e;
          e = expected_q.pop_front();
          words_checked++;
          if (out_tdata[7:0] !== e.data) report_mismatch("data_byte", e.data, out_tdata[7:0]);
          if (out_tuser !== e.role) report_mismatch("byte_role", e.role, out_tuser);
          if (out_tdata[11:8] !== e.fid) report_mismatch("frame_id", e.fid, out_tdata[11:8]);
          if (out_tlast !== e.fend) report_mismatch("frame_end", e.fend, out_tlast);
          if (out_tdata[13:12] !== e.status)
            report_mismatch("frame_status", e.status, out_tdata[13:12]);
          if (out_tdata[15:14] !== 2'b00) report_mismatch("tdata pad", 0, out_tdata[15:14]);
          if (e.fend) status_cnt[e.status]++;
        end
      end
      if (cycle_cnt % 64 == 0) ready_mode = $urandom_range(0, 3);
      case (ready_mode)
        0: out_tready <= 1'b1;
        1: out_tready <= $urandom_range(0, 9) < 7;
        2: out_tready <= (cycle_cnt % 8) < 5;
        default: out_tready <= $urandom_range(0, 9) < 3;
      endcase
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("%0t timeout with %0d words still expected", $realtime, expected_q.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed frames at the reset limit of 256
    push_byte(8'h00, 1'b1);              // end of burst while hunting does nothing
    push_byte(8'hFF, 1'b0);
    push_byte(sof_deframer_pkg::START_BYTE, 1'b0);  // zero length, sum good
    push_byte(8'hFF, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(sof_deframer_pkg::START_BYTE, 1'b0);  // zero length, sum bad
    push_byte(8'h10, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(sof_deframer_pkg::START_BYTE, 1'b0);  // length 256 rejected; beats truncation
    push_byte(8'h01, 1'b0);
    push_byte(8'h01, 1'b0);
    push_byte(8'h00, 1'b1);
    push_byte(sof_deframer_pkg::START_BYTE, 1'b0);  // two body bytes, start code in body,
    push_byte(8'h3C, 1'b0);              // burst ends on checksum: frame reports ok
    push_byte(8'h00, 1'b0);
    push_byte(8'h02, 1'b0);
    push_byte(sof_deframer_pkg::START_BYTE, 1'b0);
    push_byte(8'h67, 1'b1);
    push_byte(sof_deframer_pkg::START_BYTE, 1'b1);  // truncated on the start byte
    push_byte(sof_deframer_pkg::START_BYTE, 1'b0);  // truncated on a non-final body byte
    push_byte(8'h07, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'h02, 1'b0);
    push_byte(8'h11, 1'b1);
    drain();

    // Random traffic over a range of length limits
    run_limit(16'd0, 60);
    run_limit(16'd1, 60);
    run_limit(16'hFFFF, 150);
    run_limit(sof_deframer_pkg::MAX_LEN_RESET, 180);
    run_limit(LEN_W'($urandom_range(2, 20)), 150);
    run_limit(LEN_W'($urandom_range(1, 65535)), 100);

    $display("Checked %0d words across %0d length limits, frames closed ok/sum/len/trunc:",
             words_checked, limits_run);
    $display("  %0d / %0d / %0d / %0d", status_cnt[sof_deframer_pkg::ST_OK],
             status_cnt[sof_deframer_pkg::ST_BAD_SUM], status_cnt[sof_deframer_pkg::ST_BAD_LEN],
             status_cnt[sof_deframer_pkg::ST_TRUNC]);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d errors", errors);
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
